FILE: hdl/active_ising_particle_update_top_defines.svh
// Assertion macros for the active Ising particle update block.
`ifndef ACTIVE_ISING_PARTICLE_UPDATE_TOP_DEFINES_SVH
`define ACTIVE_ISING_PARTICLE_UPDATE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked property that is ignored while reset is asserted.
`define AIPU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("aipu assertion failed");
// Checked property that is evaluated during reset as well.
`define AIPU_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
    else $error("aipu assertion failed");
`else
`define AIPU_ASSERT(lbl, clk, rst_n, prop)
`define AIPU_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: hdl/aipu_pkg.sv
// Shared types and constants of the active Ising particle update block.
package aipu_pkg;

    localparam int MAX_SIDE      = 1024;
    localparam int MAX_OCCUPANCY = 1023;

    localparam int POS_W  = 10;
    localparam int SIDE_W = 11;
    localparam int MAG_W  = 11;
    localparam int RHO_W  = 10;
    localparam int NUM_W  = 35;
    localparam int DIV_N  = NUM_W;
    localparam int E_W    = 24;
    localparam int Q32_W  = 33;
    localparam int DDT_W  = 41;
    localparam int RDT_W  = 43;
    localparam int SUM_W  = 44;
    localparam int PROD_W = 59;
    localparam int NPOST  = 10;

    localparam logic [16:0] INV_LN2 = 17'd94548;
    localparam logic [15:0] EXP_C1  = 16'd45603;
    localparam logic [13:0] EXP_C2  = 14'd14816;
    localparam logic [12:0] EXP_C3  = 13'd5206;
    localparam logic [17:0] ONE_Q16 = 18'd65536;

    localparam logic [NUM_W-1:0] E_NEG_LIM = NUM_W'(64 * 65536);
    localparam logic [NUM_W-1:0] E_POS_LIM = NUM_W'(32 * 65536);
    localparam logic [Q32_W-1:0] ONE_Q32   = {1'b1, 32'b0};

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_FLIP  = 3'd1,
        ACT_RIGHT = 3'd2,
        ACT_LEFT  = 3'd3,
        ACT_UP    = 3'd4,
        ACT_DOWN  = 3'd5
    } t_act;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_W0     = 3'd2,
        CFG_BETA   = 3'd3,
        CFG_EPS    = 3'd4,
        CFG_HOP    = 3'd5,
        CFG_DT     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             spin;
        logic [31:0]      p;
        logic             last;
    } t_pay;

    typedef struct packed {
        logic [RHO_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] q;
        logic [RHO_W-1:0] rho;
        logic             neg;
        t_pay             pay;
    } t_div;

endpackage

FILE: hdl/active_ising_particle_update_top.sv
// Active Ising particle update: one Monte Carlo move per particle request.
// Throughput: one request per cycle unless the output stalls; the 35-stage restoring divider for beta*m/rho
// is the longest part of the pipeline and one stage of it serves each quotient bit.
// Stall from the output freezes the whole pipeline in place; nothing is lost.
// Reset (synchronous, active low) empties the pipeline and restores the registers.
`include "active_ising_particle_update_top_defines.svh"
module active_ising_particle_update_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [aipu_pkg::POS_W-1:0]  i_pos_x,
    input  logic [aipu_pkg::POS_W-1:0]  i_pos_y,
    input  logic                        i_spin,
    input  logic signed [10:0]          i_cell_magnetization,
    input  logic [aipu_pkg::RHO_W-1:0]  i_cell_density,
    input  logic [31:0]                 i_random_word,
    input  logic                        i_last_particle,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [aipu_pkg::POS_W-1:0]  o_new_x,
    output logic [aipu_pkg::POS_W-1:0]  o_new_y,
    output logic                        o_new_spin,
    output logic [2:0]                  o_action_taken,
    output logic                        o_sweep_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [23:0]                 i_cfg_data
);
    import aipu_pkg::*;

    // Configuration registers.
    logic [SIDE_W-1:0] r_width, r_height;
    logic [23:0]       r_w0, r_beta, r_hop;
    logic signed [17:0] r_eps;
    logic [16:0]       r_dt;

    // Values derived from the configuration; they are registered after a write and
    // settle long before any request reaches the stage that uses them.
    logic [SIDE_W-1:0] r_w_eff, r_h_eff;
    logic [DDT_W-1:0]  r_w0dt, r_ddt;
    logic [41:0]       r_rp_lo, r_rn_lo;
    logic [34:0]       r_rp_hi, r_rn_hi;
    logic [RDT_W-1:0]  r_rdt_pos, r_rdt_neg;
    logic [SUM_W-1:0]  r_ddt2, r_ddt3, r_ddt4;
    logic signed [18:0] fac_pos_s, fac_neg_s;
    logic [17:0]       fac_pos, fac_neg;

    // Pipeline control and stages.
    logic              en;
    logic              r_s1_valid;
    t_pay              r_s1_pay;
    logic signed [10:0] r_s1_m;
    logic [RHO_W-1:0]  r_s1_rho;
    logic [RHO_W-1:0]  n_rho;
    logic signed [11:0] s1_me;
    logic [11:0]       s1_mag;
    logic              s1_neg;

    logic              r_dv_valid [DIV_N+1];
    t_div              r_dv       [DIV_N+1];
    t_div              n_dv       [DIV_N];
    logic [RHO_W:0]    dv_sh      [DIV_N];
    logic              dv_ge      [DIV_N];

    logic [NPOST-1:0]  r_pv;
    t_pay              r_pp [NPOST];

    logic [NUM_W-1:0]  e1_lim;
    logic [E_W-1:0]    e1_mag;
    logic signed [E_W-1:0] r_e1_e;
    logic signed [41:0] r_e2_ye;
    logic signed [7:0] r_e3_n, r_e4_n, r_e5_n, r_e6_n, r_e7_n;
    logic [15:0]       r_e3_f, r_e4_f;
    logic [28:0]       r_e3_pr;
    logic [30:0]       r_e4_pr;
    logic [32:0]       r_e5_pr;
    logic [14:0]       e4_pa;
    logic [16:0]       e5_pb;
    logic [17:0]       e6_pm;
    logic [41:0]       r_e6_lo;
    logic [34:0]       r_e6_hi;
    logic [PROD_W-1:0] r_e7_prod;
    logic signed [8:0] e8_sh;
    logic [8:0]        e8_rs;
    logic [PROD_W+29:0] e8_big;
    logic [PROD_W-1:0] e8_sv;
    logic [Q32_W-1:0]  n_t0;
    logic [Q32_W-1:0]  r_t0;
    logic [Q32_W-1:0]  r_t [5];
    t_act              n_act, r_e10_act;

    logic [SIDE_W-1:0] o_xp1, o_yp1;
    logic [POS_W-1:0]  n_x, n_y;
    logic              n_spin;

    logic [POS_W-1:0]  r_o_x, r_o_y;
    logic              r_o_spin, r_o_last, r_o_valid;
    t_act              r_o_act;

    function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
        if (v == '0) begin
            return SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            return SIDE_W'(MAX_SIDE);
        end
        return v;
    endfunction

    function automatic logic [Q32_W-1:0] sat_q32(input logic [SUM_W-1:0] v);
        return (v > SUM_W'(ONE_Q32)) ? ONE_Q32 : v[Q32_W-1:0];
    endfunction

    // Configuration writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_W'(64);
            r_height <= SIDE_W'(64);
            r_w0     <= 24'd65536;
            r_beta   <= 24'd65536;
            r_eps    <= '0;
            r_hop    <= 24'd65536;
            r_dt     <= 17'd6554;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data[SIDE_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[SIDE_W-1:0];
                CFG_W0:     r_w0     <= i_cfg_data;
                CFG_BETA:   r_beta   <= i_cfg_data;
                CFG_EPS:    r_eps    <= i_cfg_data[17:0];
                CFG_HOP:    r_hop    <= i_cfg_data;
                CFG_DT:     r_dt     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // The right hop rate factor 1 + s*eps, taken as zero when it goes negative.
    always_comb begin
        fac_pos_s = 19'sd65536 + 19'(r_eps);
        fac_neg_s = 19'sd65536 - 19'(r_eps);
        fac_pos   = fac_pos_s[18] ? 18'd0 : fac_pos_s[17:0];
        fac_neg   = fac_neg_s[18] ? 18'd0 : fac_neg_s[17:0];
    end

    always_ff @(posedge i_clk) begin
        r_w_eff   <= side_clamp(r_width);
        r_h_eff   <= side_clamp(r_height);
        r_w0dt    <= r_w0 * r_dt;
        r_ddt     <= r_hop * r_dt;
        // D*dt*(1+s*eps) in two partial products to keep the multipliers narrow.
        r_rp_lo   <= r_ddt[23:0] * fac_pos;
        r_rp_hi   <= r_ddt[DDT_W-1:24] * fac_pos;
        r_rn_lo   <= r_ddt[23:0] * fac_neg;
        r_rn_hi   <= r_ddt[DDT_W-1:24] * fac_neg;
        r_rdt_pos <= RDT_W'(((PROD_W'(r_rp_hi) << 24) + PROD_W'(r_rp_lo)) >> 16);
        r_rdt_neg <= RDT_W'(((PROD_W'(r_rn_hi) << 24) + PROD_W'(r_rn_lo)) >> 16);
        r_ddt2    <= SUM_W'(r_ddt) << 1;
        r_ddt3    <= SUM_W'(r_ddt) + (SUM_W'(r_ddt) << 1);
        r_ddt4    <= SUM_W'(r_ddt) << 2;
    end

    // The pipeline moves as one; it only holds while a finished result waits.
    assign en      = !(r_o_valid && i_stall);
    assign o_stall = !en;

    // A density of zero counts as one particle.
    always_comb begin
        n_rho = (i_cell_density == '0) ? RHO_W'(1) : i_cell_density;
        if (RHO_W'(MAX_OCCUPANCY) < n_rho) begin
            n_rho = RHO_W'(MAX_OCCUPANCY);
        end
    end

    // Sign and magnitude of -s*m; the exponent is divided in magnitude form and
    // the sign put back afterwards, which matches truncation toward zero.
    always_comb begin
        s1_me  = {r_s1_m[10], r_s1_m};
        s1_mag = r_s1_m[10] ? 12'(-s1_me) : 12'(s1_me);
        s1_neg = r_s1_pay.spin ? (!r_s1_m[10] && (r_s1_m != '0)) : r_s1_m[10];
    end

    // One quotient bit per divider stage.
    always_comb begin
        for (int k = 0; k < DIV_N; k++) begin
            dv_sh[k] = {r_dv[k].rem, r_dv[k].num[NUM_W-1]};
            dv_ge[k] = dv_sh[k] >= {1'b0, r_dv[k].rho};
            n_dv[k]  = r_dv[k];
            n_dv[k].rem = dv_ge[k] ? RHO_W'(dv_sh[k] - {1'b0, r_dv[k].rho})
                                   : dv_sh[k][RHO_W-1:0];
            n_dv[k].num = r_dv[k].num << 1;
            n_dv[k].q   = {r_dv[k].q[NUM_W-2:0], dv_ge[k]};
        end
    end

    // The exponent is clamped to the range that the 2^x approximation covers.
    always_comb begin
        e1_lim = r_dv[DIV_N].neg ? E_NEG_LIM : E_POS_LIM;
        e1_mag = (r_dv[DIV_N].q > e1_lim) ? E_W'(e1_lim) : E_W'(r_dv[DIV_N].q);
    end

    // Horner steps of the 2^f cubic, each product truncated to Q16.
    always_comb begin
        e4_pa = 15'(EXP_C2) + 15'(r_e3_pr[28:16]);
        e5_pb = 17'(EXP_C1) + 17'(r_e4_pr[30:16]);
        e6_pm = ONE_Q16 + 18'(r_e5_pr[32:16]);
    end

    // Scale w0*mant*dt by 2^(n-16) and saturate at one.
    always_comb begin
        e8_sh  = $signed({r_e7_n[7], r_e7_n}) - 9'sd16;
        e8_rs  = 9'(-e8_sh);
        e8_big = (PROD_W+30)'(r_e7_prod) << e8_sh[4:0];
        e8_sv  = r_e7_prod >> e8_rs[5:0];
        if (!e8_sh[8]) begin
            n_t0 = (e8_big > (PROD_W+30)'(ONE_Q32)) ? ONE_Q32 : e8_big[Q32_W-1:0];
        end else if (e8_rs >= 9'd64) begin
            n_t0 = '0;
        end else begin
            n_t0 = (e8_sv > PROD_W'(ONE_Q32)) ? ONE_Q32 : e8_sv[Q32_W-1:0];
        end
    end

    // The first threshold above the random word picks the move.
    always_comb begin
        if ({1'b0, r_pp[8].p} < r_t[0]) begin
            n_act = ACT_FLIP;
        end else if ({1'b0, r_pp[8].p} < r_t[1]) begin
            n_act = ACT_RIGHT;
        end else if ({1'b0, r_pp[8].p} < r_t[2]) begin
            n_act = ACT_LEFT;
        end else if ({1'b0, r_pp[8].p} < r_t[3]) begin
            n_act = ACT_UP;
        end else if ({1'b0, r_pp[8].p} < r_t[4]) begin
            n_act = ACT_DOWN;
        end else begin
            n_act = ACT_NONE;
        end
    end

    // Periodic wrap: one subtraction of the side on the way up, side-1 from zero.
    always_comb begin
        o_xp1  = {1'b0, r_pp[9].x} + SIDE_W'(1);
        o_yp1  = {1'b0, r_pp[9].y} + SIDE_W'(1);
        n_x    = r_pp[9].x;
        n_y    = r_pp[9].y;
        n_spin = r_pp[9].spin;
        case (r_e10_act)
            ACT_FLIP:  n_spin = !r_pp[9].spin;
            ACT_RIGHT: n_x = (o_xp1 >= r_w_eff) ? POS_W'(o_xp1 - r_w_eff) : POS_W'(o_xp1);
            ACT_LEFT:  n_x = (r_pp[9].x == '0) ? POS_W'(r_w_eff - SIDE_W'(1))
                                               : r_pp[9].x - POS_W'(1);
            ACT_UP:    n_y = (o_yp1 >= r_h_eff) ? POS_W'(o_yp1 - r_h_eff) : POS_W'(o_yp1);
            ACT_DOWN:  n_y = (r_pp[9].y == '0) ? POS_W'(r_h_eff - SIDE_W'(1))
                                               : r_pp[9].y - POS_W'(1);
            default: ;
        endcase
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int k = 0; k <= DIV_N; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
            r_pv      <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid    <= i_valid;
            r_dv_valid[0] <= r_s1_valid;
            for (int k = 0; k < DIV_N; k++) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            r_pv      <= {r_pv[NPOST-2:0], r_dv_valid[DIV_N]};
            r_o_valid <= r_pv[NPOST-1];
        end
    end

    // Data of every stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pay <= '{x: i_pos_x, y: i_pos_y, spin: i_spin,
                          p: i_random_word, last: i_last_particle};
            r_s1_m   <= i_cell_magnetization;
            r_s1_rho <= n_rho;

            r_dv[0].rem <= '0;
            r_dv[0].num <= r_beta * s1_mag[MAG_W-1:0];
            r_dv[0].q   <= '0;
            r_dv[0].rho <= r_s1_rho;
            r_dv[0].neg <= s1_neg;
            r_dv[0].pay <= r_s1_pay;
            for (int k = 0; k < DIV_N; k++) begin
                r_dv[k+1] <= n_dv[k];
            end

            r_pp[0] <= r_dv[DIV_N].pay;
            for (int j = 1; j < NPOST; j++) begin
                r_pp[j] <= r_pp[j-1];
            end

            r_e1_e  <= r_dv[DIV_N].neg ? -$signed(e1_mag) : $signed(e1_mag);
            r_e2_ye <= r_e1_e * $signed({1'b0, INV_LN2});
            r_e3_n  <= r_e2_ye[39:32];
            r_e3_f  <= r_e2_ye[31:16];
            r_e3_pr <= EXP_C3 * r_e2_ye[31:16];
            r_e4_n  <= r_e3_n;
            r_e4_f  <= r_e3_f;
            r_e4_pr <= e4_pa * r_e3_f;
            r_e5_n  <= r_e4_n;
            r_e5_pr <= e5_pb * r_e4_f;
            r_e6_n  <= r_e5_n;
            r_e6_lo <= r_w0dt[23:0] * e6_pm;
            r_e6_hi <= r_w0dt[DDT_W-1:24] * e6_pm;
            r_e7_n  <= r_e6_n;
            r_e7_prod <= (PROD_W'(r_e6_hi) << 24) + PROD_W'(r_e6_lo);
            r_t0    <= n_t0;

            r_t[0] <= r_t0;
            r_t[1] <= sat_q32(SUM_W'(r_t0) +
                              SUM_W'(r_pp[7].spin ? r_rdt_pos : r_rdt_neg));
            r_t[2] <= sat_q32(SUM_W'(r_t0) + r_ddt2);
            r_t[3] <= sat_q32(SUM_W'(r_t0) + r_ddt3);
            r_t[4] <= sat_q32(SUM_W'(r_t0) + r_ddt4);

            r_e10_act <= n_act;

            r_o_x    <= n_x;
            r_o_y    <= n_y;
            r_o_spin <= n_spin;
            r_o_act  <= r_e10_act;
            r_o_last <= r_pp[9].last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_new_x        = r_o_x;
    assign o_new_y        = r_o_y;
    assign o_new_spin     = r_o_spin;
    assign o_action_taken = r_o_act;
    assign o_sweep_end    = r_o_last;

    // The divider leaves a remainder below the divisor.
    `AIPU_ASSERT(a_div_rem, i_clk, i_rst_n, r_dv_valid[DIV_N] |-> (r_dv[DIV_N].rem < r_dv[DIV_N].rho))
    // The hop thresholds after the right hop only grow, and none passes one.
    `AIPU_ASSERT(a_thr_order, i_clk, i_rst_n, r_pv[8] |-> (r_t[2] <= r_t[3] && r_t[3] <= r_t[4] && r_t[4] <= ONE_Q32))
    // A held result freezes every stage behind it.
    `AIPU_ASSERT(a_stall_freeze, i_clk, i_rst_n, (r_o_valid && i_stall) |=> $stable(r_pv))
    // Reset empties the pipeline.
    `AIPU_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> (!r_o_valid && r_pv == '0 && !r_s1_valid))

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the active Ising particle update block.
`timescale 1ns / 100ps
module tb;
    import aipu_pkg::*;

    // A bench-side ceiling on the run; the slowest legal run needs far fewer cycles.
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     PIPE_DEPTH  = 47;
    localparam longint ONE_Q       = 64'h1_0000_0000;

    // One expected particle move, field for field as the block reports it.
    typedef struct {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             spin;
        t_act             act;
        logic             last;
    } t_move;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [POS_W-1:0]         i_pos_x;
    logic [POS_W-1:0]         i_pos_y;
    logic                     i_spin;
    logic signed [10:0]       i_cell_magnetization;
    logic [RHO_W-1:0]         i_cell_density;
    logic [31:0]              i_random_word;
    logic                     i_last_particle;
    logic                     o_valid;
    logic                     i_stall;
    logic [POS_W-1:0]         o_new_x;
    logic [POS_W-1:0]         o_new_y;
    logic                     o_new_spin;
    logic [2:0]               o_action_taken;
    logic                     o_sweep_end;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [2:0]               i_cfg_index;
    logic [23:0]              i_cfg_data;

    // Bench copy of the register file, updated whenever a write is accepted.
    logic [10:0]              lat_width;
    logic [10:0]              lat_height;
    logic [23:0]              rate_w0;
    logic [23:0]              rate_beta;
    logic signed [17:0]       rate_eps;
    logic [23:0]              rate_hop;
    logic [16:0]              rate_dt;

    t_move                    pending_moves[$];
    int                       mismatches;
    int                       cycle_count;
    bit                       calm;       // when set, neither side idles outside a hold-off
    bit                       hold_req;   // asks the receiver for a long hold-off
    int                       hold_left;

    active_ising_particle_update_top u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_pos_x              (i_pos_x),
        .i_pos_y              (i_pos_y),
        .i_spin               (i_spin),
        .i_cell_magnetization (i_cell_magnetization),
        .i_cell_density       (i_cell_density),
        .i_random_word        (i_random_word),
        .i_last_particle      (i_last_particle),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_new_x              (o_new_x),
        .o_new_y              (o_new_y),
        .o_new_spin           (o_new_spin),
        .o_action_taken       (o_action_taken),
        .o_sweep_end          (o_sweep_end),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint sat_q32(longint v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

    function automatic int side_used(logic [10:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    // Builds the five cumulative Q0.32 thresholds: flip, right, left, up, down.
    function automatic void form_thresholds(input logic spin, input logic signed [10:0] mag,
                                            input logic [RHO_W-1:0] dens,
                                            output longint thr[5]);
        longint s, m, rho, e, yb, ys, n, f, mant, prod, ddt, fac, rdt, t0;
        int     sh;
        s   = spin ? 1 : -1;
        m   = longint'(mag);
        rho = longint'(dens);
        if (rho == 0) rho = 1;
        if (rho > MAX_OCCUPANCY) rho = MAX_OCCUPANCY;
        e = (longint'(rate_beta) * (-s * m)) / rho;
        if (e < -64 * 65536) e = -64 * 65536;
        if (e > 32 * 65536) e = 32 * 65536;
        // Floor division by 2^16 on a value biased to stay non-negative.
        yb = e * 94548 + (longint'(128) << 32);
        ys = (yb >>> 16) - (longint'(128) << 16);
        yb = ys + (longint'(128) << 16);
        n  = (yb >>> 16) - 128;
        f  = yb & 64'hFFFF;
        mant = 5206;
        mant = 14816 + ((mant * f) >>> 16);
        mant = 45603 + ((mant * f) >>> 16);
        mant = 65536 + ((mant * f) >>> 16);
        prod = longint'(rate_w0) * mant * longint'(rate_dt);
        sh   = int'(n - 16);
        if (prod == 0) begin
            t0 = 0;
        end else if (sh >= 0) begin
            if (sh > 32) t0 = ONE_Q;
            else if (prod > (ONE_Q >>> sh)) t0 = ONE_Q;
            else t0 = prod <<< sh;
        end else if (-sh >= 64) begin
            t0 = 0;
        end else begin
            t0 = sat_q32(prod >>> (-sh));
        end
        ddt = longint'(rate_hop) * longint'(rate_dt);
        fac = 65536 + s * longint'(rate_eps);
        if (fac < 0) fac = 0;
        rdt = (longint'(rate_hop) * fac * longint'(rate_dt)) >>> 16;
        thr[0] = t0;
        thr[1] = sat_q32(t0 + rdt);
        thr[2] = sat_q32(t0 + 2 * ddt);
        thr[3] = sat_q32(t0 + 3 * ddt);
        thr[4] = sat_q32(t0 + 4 * ddt);
    endfunction

    function automatic t_move predict_move(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                           logic spin, logic signed [10:0] mag,
                                           logic [RHO_W-1:0] dens, logic [31:0] word,
                                           logic last);
        longint thr[5];
        longint p;
        int     w, h, nx, ny;
        t_move  mv;
        form_thresholds(spin, mag, dens, thr);
        w  = side_used(lat_width);
        h  = side_used(lat_height);
        p  = longint'(word);
        nx = int'(x);
        ny = int'(y);
        mv.spin = spin;
        mv.act  = ACT_NONE;
        if (p < thr[0]) begin
            mv.spin = ~spin;
            mv.act  = ACT_FLIP;
        end else if (p < thr[1]) begin
            nx = nx + 1;
            if (nx >= w) nx = nx - w;
            mv.act = ACT_RIGHT;
        end else if (p < thr[2]) begin
            nx = (nx == 0) ? w - 1 : nx - 1;
            mv.act = ACT_LEFT;
        end else if (p < thr[3]) begin
            ny = ny + 1;
            if (ny >= h) ny = ny - h;
            mv.act = ACT_UP;
        end else if (p < thr[4]) begin
            ny = (ny == 0) ? h - 1 : ny - 1;
            mv.act = ACT_DOWN;
        end
        mv.x    = nx[POS_W-1:0];
        mv.y    = ny[POS_W-1:0];
        mv.last = last;
        return mv;
    endfunction

    // Picks a random word inside the band of one action, or anywhere.
    function automatic logic [31:0] pick_word(logic spin, logic signed [10:0] mag,
                                              logic [RHO_W-1:0] dens, int band);
        longint thr[5];
        longint lo, hi, r;
        form_thresholds(spin, mag, dens, thr);
        r = longint'($urandom);
        if (band > 5) return r[31:0];
        if (band == 5) begin
            lo = thr[4];
            hi = ONE_Q;
        end else begin
            lo = (band == 0) ? 0 : thr[band - 1];
            hi = thr[band];
        end
        if (hi <= lo) return r[31:0];
        return 32'(lo + (r % (hi - lo)));
    endfunction

    // Sends one particle request and records its predicted move on acceptance.
    task automatic send_particle(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic spin,
                                 logic signed [10:0] mag, logic [RHO_W-1:0] dens,
                                 logic [31:0] word, logic last);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pos_x              <= x;
        i_pos_y              <= y;
        i_spin               <= spin;
        i_cell_magnetization <= mag;
        i_cell_density       <= dens;
        i_random_word        <= word;
        i_last_particle      <= last;
        i_valid              <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_moves.push_back(predict_move(x, y, spin, mag, dens, word, last));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WIDTH:  lat_width  = data[10:0];
            CFG_HEIGHT: lat_height = data[10:0];
            CFG_W0:     rate_w0    = data;
            CFG_BETA:   rate_beta  = data;
            CFG_EPS:    rate_eps   = data[17:0];
            CFG_HOP:    rate_hop   = data;
            CFG_DT:     rate_dt    = data[16:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Every request yields a move, so an empty queue means the pipeline is empty.
    task automatic drain_moves();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_rates(logic [10:0] w, logic [10:0] h, logic [23:0] w0,
                              logic [23:0] beta, logic [17:0] eps, logic [23:0] hop,
                              logic [16:0] dt);
        write_reg(CFG_WIDTH, 24'(w));
        write_reg(CFG_HEIGHT, 24'(h));
        write_reg(CFG_W0, w0);
        write_reg(CFG_BETA, beta);
        write_reg(CFG_EPS, 24'(eps));
        write_reg(CFG_HOP, hop);
        write_reg(CFG_DT, 24'(dt));
    endtask

    // Random particle with a word aimed at one of the action bands most of the time.
    task automatic send_random_particle();
        logic [POS_W-1:0]   x, y;
        logic               spin;
        logic signed [10:0] mag;
        logic [RHO_W-1:0]   dens;
        int                 band;
        x    = ($urandom_range(3) == 0) ? 10'($urandom_range(1) * 1023) : 10'($urandom);
        y    = ($urandom_range(3) == 0) ? 10'($urandom_range(1) * 1023) : 10'($urandom);
        spin = $urandom_range(1);
        mag  = ($urandom_range(1) == 0) ? 11'($urandom) : 11'($signed($urandom_range(40)) - 20);
        dens = ($urandom_range(7) == 0) ? 10'd0 : 10'($urandom);
        band = $urandom_range(7);
        send_particle(x, y, spin, mag, dens, pick_word(spin, mag, dens, band),
                      ($urandom_range(7) == 0));
    endtask

    // Reset values should give a sane move for particles of each kind.
    task automatic test_reset_rates();
        int band;
        for (band = 0; band < 6; band++) begin
            send_particle(10'd5, 10'd7, band[0], 11'sd3, 10'd4,
                          pick_word(band[0], 11'sd3, 10'd4, band), band[0]);
        end
        drain_moves();
    endtask

    // Field extremes and wrap at the lattice edges, including a zero density.
    task automatic test_field_extremes();
        send_particle(10'd0, 10'd0, 1'b0, -11'sd1024, 10'd0, 32'd0, 1'b1);
        send_particle(10'd1023, 10'd1023, 1'b1, 11'sd1023, 10'd1023, 32'hFFFF_FFFF, 1'b0);
        send_particle(10'd0, 10'd0, 1'b1, 11'sd0, 10'd1, pick_word(1'b1, 11'sd0, 10'd1, 2), 1'b0);
        send_particle(10'd0, 10'd0, 1'b1, 11'sd0, 10'd1, pick_word(1'b1, 11'sd0, 10'd1, 4), 1'b0);
        send_particle(10'd63, 10'd63, 1'b0, 11'sd0, 10'd1, pick_word(1'b0, 11'sd0, 10'd1, 1), 1'b0);
        send_particle(10'd63, 10'd63, 1'b0, 11'sd0, 10'd1, pick_word(1'b0, 11'sd0, 10'd1, 3), 1'b1);
        // Positions outside the lattice.
        send_particle(10'd1000, 10'd900, 1'b1, 11'sd2, 10'd0, pick_word(1'b1, 11'sd2, 10'd0, 1), 1'b0);
        send_particle(10'd1000, 10'd900, 1'b1, 11'sd2, 10'd0, pick_word(1'b1, 11'sd2, 10'd0, 3), 1'b0);
        drain_moves();
    endtask

    // Bad lattice sizes and the propulsion extremes, where a right hop can vanish.
    task automatic test_sizes_and_bias();
        load_rates(11'd0, 11'd2047, 24'd65536, 24'd65536, 18'h30000, 24'd65536, 17'd6554);
        send_particle(10'd0, 10'd1023, 1'b1, 11'sd1, 10'd2, pick_word(1'b1, 11'sd1, 10'd2, 1), 1'b0);
        send_particle(10'd0, 10'd1023, 1'b1, 11'sd1, 10'd2, pick_word(1'b1, 11'sd1, 10'd2, 2), 1'b0);
        send_particle(10'd0, 10'd1023, 1'b1, 11'sd1, 10'd2, pick_word(1'b1, 11'sd1, 10'd2, 3), 1'b1);
        drain_moves();
        load_rates(11'd1024, 11'd1, 24'd0, 24'd0, 18'd65536, 24'hFFFFFF, 17'd65536);
        send_particle(10'd1023, 10'd0, 1'b1, 11'sd5, 10'd3, 32'd12345, 1'b0);
        send_particle(10'd1023, 10'd0, 1'b0, 11'sd5, 10'd3, 32'hFFFF_FFFF, 1'b1);
        drain_moves();
        load_rates(11'd17, 11'd9, 24'hFFFFFF, 24'hFFFFFF, 18'd0, 24'd0, 17'd0);
        send_particle(10'd16, 10'd8, 1'b0, 11'sd1023, 10'd1, 32'd0, 1'b0);
        drain_moves();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        int k;
        load_rates(11'd64, 11'd64, 24'd65536, 24'd65536, 18'd0, 24'd65536, 17'd6554);
        calm     = 1'b1;
        hold_req = 1'b1;
        for (k = 0; k < 120; k++) send_random_particle();
        calm = 1'b0;
        drain_moves();
    endtask

    // Random phases, each with its own register setting.
    task automatic test_random_sweeps();
        int phase, k;
        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0: load_rates(11'd1024, 11'd1024, 24'hFFFFFF, 24'hFFFFFF, 18'h30000,
                              24'hFFFFFF, 17'd65536);
                1: load_rates(11'd1, 11'd1, 24'd0, 24'd0, 18'd65536, 24'd0, 17'd0);
                default: load_rates(11'($urandom), 11'($urandom),
                                    24'($urandom_range(1 << 20)), 24'($urandom),
                                    18'($signed($urandom_range(131072)) - 65536),
                                    24'($urandom_range(1 << 20)),
                                    17'($urandom_range(65536)));
            endcase
            calm = (phase == 4);
            for (k = 0; k < 140; k++) send_random_particle();
            calm = 1'b0;
            drain_moves();
        end
    endtask

    // Receiver side: random stall, a calm stretch, and a counted long hold-off.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req  = 1'b0;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 33);
        end
    end

    // Compares each delivered move with the oldest prediction.
    always @(posedge i_clk) begin
        t_move mv;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_moves.size() == 0) begin
                $display("%0t: unexpected move x=%0d y=%0d", $time, o_new_x, o_new_y);
                mismatches++;
            end else begin
                mv = pending_moves.pop_front();
                if (o_new_x !== mv.x) begin
                    $display("%0t: new_x expected %0d actual %0d", $time, mv.x, o_new_x);
                    mismatches++;
                end
                if (o_new_y !== mv.y) begin
                    $display("%0t: new_y expected %0d actual %0d", $time, mv.y, o_new_y);
                    mismatches++;
                end
                if (o_new_spin !== mv.spin) begin
                    $display("%0t: new_spin expected %0d actual %0d", $time, mv.spin,
                             o_new_spin);
                    mismatches++;
                end
                if (o_action_taken !== mv.act) begin
                    $display("%0t: action expected %0d actual %0d", $time, mv.act,
                             o_action_taken);
                    mismatches++;
                end
                if (o_sweep_end !== mv.last) begin
                    $display("%0t: sweep_end expected %0d actual %0d", $time, mv.last,
                             o_sweep_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_stall              = 1'b0;
        i_pos_x              = '0;
        i_pos_y              = '0;
        i_spin               = 1'b0;
        i_cell_magnetization = '0;
        i_cell_density       = '0;
        i_random_word        = '0;
        i_last_particle      = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_index          = '0;
        i_cfg_data           = '0;
        lat_width            = 11'd64;
        lat_height           = 11'd64;
        rate_w0              = 24'd65536;
        rate_beta            = 24'd65536;
        rate_eps             = 18'sd0;
        rate_hop             = 24'd65536;
        rate_dt              = 17'd6554;
        mismatches           = 0;
        cycle_count          = 0;
        calm                 = 1'b0;
        hold_req             = 1'b0;
        hold_left            = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_rates();
        test_field_extremes();
        test_sizes_and_bias();
        test_backpressure();
        test_random_sweeps();

        // Let any straggler surface before judging the run.
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (mismatches == 0 && pending_moves.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/aipu_pkg.sv
hdl/active_ising_particle_update_top.sv
bench/tb.sv
